// ===== rtl/core/cdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Countdown timer package
// Shared types, constants and digit helpers for the countdown timer block.
// ----------------------------------------------------------------------------
`default_nettype none

package cdt_pkg;

    localparam int unsigned HOURS_W = 7;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam logic [HOURS_W-1:0] HOURS_MAX   = 7'd99;
    localparam logic [HOURS_W-1:0] LIMIT_RESET = 7'd59;
    localparam logic [MIN_W-1:0]   UNIT_MAX    = 6'd59;
    localparam logic [DIGIT_W-1:0] DIGIT_BLANK = 4'd10;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 4'd9;

    // Word index of the configuration register (byte address bit 2).
    localparam logic REG_HOURS_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SNOOZE = 2'd1,
        OP_UP     = 2'd2,
        OP_DOWN   = 2'd3
    } t_op;

    typedef struct packed {
        logic [HOURS_W-1:0] h;
        logic [MIN_W-1:0]   m;
        logic [SEC_W-1:0]   s;
    } t_hms;

    localparam t_hms HMS_RESET = '{h: 7'd0, m: 6'd1, s: 6'd0};
    localparam t_hms HMS_ZERO  = '{h: 7'd0, m: 6'd0, s: 6'd0};

    // One input beat as held in the input stage.
    typedef struct packed {
        t_op  op;
        logic set_mode;
    } t_evt;

    // One result beat.
    typedef struct packed {
        logic [DIGIT_W-1:0] digit_one;
        logic [DIGIT_W-1:0] digit_two;
        logic [DIGIT_W-1:0] digit_three;
        logic [DIGIT_W-1:0] digit_four;
        logic               colon_on;
        logic               hours_view;
        logic               running;
        logic               expired;
        logic               start_beep;
    } t_res;

    // Tens digit of a value up to 99: multiply by 205/2048.
    function automatic logic [DIGIT_W-1:0] tens_of(input logic [HOURS_W-1:0] v);
        logic [14:0] prod;
        prod = 15'(v) * 15'd205;
        return prod[14:11];
    endfunction

    function automatic logic [DIGIT_W-1:0] ones_of(input logic [HOURS_W-1:0] v);
        logic [HOURS_W-1:0] tens;
        logic [HOURS_W-1:0] rem;
        tens = {3'b000, tens_of(v)};
        rem  = v - 7'(tens * 7'd10);
        return rem[DIGIT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cdt_evt_if.sv =====
// ----------------------------------------------------------------------------
// Countdown timer event channel
// Valid/ready channel that carries one tick or button press per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdt_evt_if;
    logic         valid;
    logic         ready;
    cdt_pkg::t_op op;
    logic         set_mode;

    modport source (output valid, output op, output set_mode, input ready);
    modport sink   (input valid, input op, input set_mode, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cdt_res_if.sv =====
// ----------------------------------------------------------------------------
// Countdown timer result channel
// Valid/ready channel that carries display digits and status bits per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdt_res_if;
    logic                          valid;
    logic                          ready;
    logic [cdt_pkg::DIGIT_W-1:0]   digit_one;
    logic [cdt_pkg::DIGIT_W-1:0]   digit_two;
    logic [cdt_pkg::DIGIT_W-1:0]   digit_three;
    logic [cdt_pkg::DIGIT_W-1:0]   digit_four;
    logic                          colon_on;
    logic                          hours_view;
    logic                          running;
    logic                          expired;
    logic                          start_beep;

    modport source (
        output valid, output digit_one, output digit_two, output digit_three,
        output digit_four, output colon_on, output hours_view, output running,
        output expired, output start_beep, input ready
    );
    modport sink (
        input valid, input digit_one, input digit_two, input digit_three,
        input digit_four, input colon_on, input hours_view, input running,
        input expired, input start_beep, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/countdown_timer_controller.sv =====
// ----------------------------------------------------------------------------
// Countdown timer controller
// Hours/minutes/seconds countdown with preset editing and a four-digit view.
// ----------------------------------------------------------------------------
// The block takes one event beat per cycle while results are taken: a
// one-second tick or a snooze, up or down press, sampled together with the
// set-mode switch level. Every event beat yields exactly one result beat
// with four display digits and status bits. An event first lands in an
// input register; once the result register is free, the core updates
// count, preset and flags and loads the result register, and a new event
// can be accepted in that same cycle. The result register and the input
// register together decouple the two channels: while a result waits, one
// more event is taken and held. The hours limit register sits at byte
// address 0 of the APB-style port; it resets to 59, and values above 99
// behave as 99. It should only be written while no event is in flight.
`default_nettype none

module countdown_timer_controller (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    cdt_evt_if.sink                            i_evt,
    cdt_res_if.source                          o_res,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cdt_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [cdt_pkg::PDATA_W-1:0]   pwdata,
    output logic      [cdt_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    logic                        r_in_valid;
    cdt_pkg::t_evt               r_in;
    logic                        r_out_valid;
    logic                        w_advance;
    logic                        w_in_ready;
    logic [cdt_pkg::HOURS_W-1:0] w_hours_limit;
    cdt_pkg::t_res               w_res;

    cdt_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_hours_limit (w_hours_limit)
    );

    // The held event moves into the core whenever the result register is
    // empty or its beat is taken this cycle.
    assign w_advance  = r_in_valid && (!r_out_valid || o_res.ready);
    assign w_in_ready = !r_in_valid || w_advance;
    assign i_evt.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.valid && w_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && w_in_ready) begin
            r_in.op       <= i_evt.op;
            r_in.set_mode <= i_evt.set_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    cdt_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_advance),
        .i_evt         (r_in),
        .i_hours_limit (w_hours_limit),
        .o_res         (w_res)
    );

    assign o_res.valid       = r_out_valid;
    assign o_res.digit_one   = w_res.digit_one;
    assign o_res.digit_two   = w_res.digit_two;
    assign o_res.digit_three = w_res.digit_three;
    assign o_res.digit_four  = w_res.digit_four;
    assign o_res.colon_on    = w_res.colon_on;
    assign o_res.hours_view  = w_res.hours_view;
    assign o_res.running     = w_res.running;
    assign o_res.expired     = w_res.expired;
    assign o_res.start_beep  = w_res.start_beep;

endmodule

`default_nettype wire

// ===== rtl/core/cdt_regs.sv =====
// ----------------------------------------------------------------------------
// Countdown timer configuration registers
// APB-style register file holding the hours limit.
// ----------------------------------------------------------------------------
`default_nettype none

module cdt_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cdt_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [cdt_pkg::PDATA_W-1:0]   pwdata,
    output logic      [cdt_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    output logic      [cdt_pkg::HOURS_W-1:0]   o_hours_limit
);

    logic [cdt_pkg::HOURS_W-1:0] r_hours_limit;
    logic                        w_sel_limit;

    // Word addressing: the byte offset within the word is ignored.
    assign w_sel_limit = (paddr[2] == cdt_pkg::REG_HOURS_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hours_limit <= cdt_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_limit) begin
            r_hours_limit <= pwdata[cdt_pkg::HOURS_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_limit) begin
            prdata = {{(cdt_pkg::PDATA_W-cdt_pkg::HOURS_W){1'b0}}, r_hours_limit};
        end
    end

    assign pready        = 1'b1;
    assign o_hours_limit = r_hours_limit;

endmodule

`default_nettype wire

// ===== rtl/core/cdt_core.sv =====
// ----------------------------------------------------------------------------
// Countdown timer core
// Count, preset and flag state with a registered update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdt_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire cdt_pkg::t_evt                i_evt,
    input  wire logic [cdt_pkg::HOURS_W-1:0]  i_hours_limit,
    output cdt_pkg::t_res                     o_res
);

    cdt_pkg::t_hms r_count, n_count;
    cdt_pkg::t_hms r_preset, n_preset;
    logic          r_run, n_run;
    logic          r_unit, n_unit;
    logic          r_colon, n_colon;
    cdt_pkg::t_res r_res, n_res;

    cdt_pkg::t_hms         w_ticked;
    cdt_pkg::t_hms         w_view;
    logic [cdt_pkg::HOURS_W-1:0] w_lim;
    logic                  w_expired;
    logic                  w_beep;

    // Add one minute or one second, carrying upward; hours stop at the limit.
    function automatic cdt_pkg::t_hms step_up(input cdt_pkg::t_hms t, input logic by_min,
                                              input logic [cdt_pkg::HOURS_W-1:0] lim);
        cdt_pkg::t_hms r;
        logic          carry;
        r     = t;
        carry = 1'b1;
        if (!by_min) begin
            if (t.s == cdt_pkg::UNIT_MAX) begin
                r.s = '0;
            end else begin
                r.s   = t.s + 6'd1;
                carry = 1'b0;
            end
        end
        if (carry) begin
            if (t.m == cdt_pkg::UNIT_MAX) begin
                r.m = '0;
                r.h = (t.h >= lim) ? lim : t.h + 7'd1;
            end else begin
                r.m = t.m + 6'd1;
            end
        end
        return r;
    endfunction

    // Subtract one minute or one second with borrow; a value below one
    // step with nothing to borrow from is left alone.
    function automatic cdt_pkg::t_hms step_down(input cdt_pkg::t_hms t, input logic by_min);
        cdt_pkg::t_hms r;
        r = t;
        if (!by_min && t.s != '0) begin
            r.s = t.s - 6'd1;
        end else if (t.m == '0 && t.h == '0) begin
            r = t;
        end else begin
            if (t.m == '0) begin
                r.h = t.h - 7'd1;
                r.m = cdt_pkg::UNIT_MAX;
            end else begin
                r.m = t.m - 6'd1;
            end
            r.s = by_min ? t.s : cdt_pkg::UNIT_MAX;
        end
        return r;
    endfunction

    assign w_lim    = (i_hours_limit > cdt_pkg::HOURS_MAX) ? cdt_pkg::HOURS_MAX : i_hours_limit;
    assign w_ticked = step_down(r_count, 1'b0);

    always_comb begin
        n_count   = r_count;
        n_preset  = r_preset;
        n_run     = r_run;
        n_unit    = r_unit;
        n_colon   = r_colon;
        w_expired = 1'b0;
        w_beep    = 1'b0;
        unique case (i_evt.op)
            cdt_pkg::OP_TICK: begin
                n_colon = !r_colon;
                if (r_run) begin
                    if (w_ticked == cdt_pkg::HMS_ZERO) begin
                        n_run     = 1'b0;
                        n_count   = r_preset;
                        w_expired = 1'b1;
                    end else begin
                        n_count = w_ticked;
                    end
                end
            end
            cdt_pkg::OP_SNOOZE: begin
                if (i_evt.set_mode) begin
                    n_unit = !r_unit;
                end else begin
                    n_run  = !r_run;
                    w_beep = !r_run;
                end
            end
            cdt_pkg::OP_UP: begin
                if (i_evt.set_mode) begin
                    n_preset = step_up(r_preset, r_unit, w_lim);
                end else begin
                    n_run   = 1'b0;
                    n_count = r_preset;
                end
            end
            cdt_pkg::OP_DOWN: begin
                if (i_evt.set_mode) begin
                    n_preset = step_down(r_preset, r_unit);
                end
            end
            default: begin
            end
        endcase
    end

    // Display digits come from the state after this beat's update.
    assign w_view = i_evt.set_mode ? n_preset : n_count;

    always_comb begin
        if (n_unit) begin
            n_res.digit_one   = (w_view.h > 7'd9) ? cdt_pkg::tens_of(w_view.h)
                                                   : cdt_pkg::DIGIT_BLANK;
            n_res.digit_two   = cdt_pkg::ones_of(w_view.h);
            n_res.digit_three = cdt_pkg::tens_of({1'b0, w_view.m});
            n_res.digit_four  = cdt_pkg::ones_of({1'b0, w_view.m});
        end else begin
            n_res.digit_one   = cdt_pkg::tens_of({1'b0, w_view.m});
            n_res.digit_two   = cdt_pkg::ones_of({1'b0, w_view.m});
            n_res.digit_three = cdt_pkg::tens_of({1'b0, w_view.s});
            n_res.digit_four  = cdt_pkg::ones_of({1'b0, w_view.s});
        end
        n_res.colon_on   = n_colon;
        n_res.hours_view = n_unit;
        n_res.running    = n_run;
        n_res.expired    = w_expired;
        n_res.start_beep = w_beep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= cdt_pkg::HMS_RESET;
            r_preset <= cdt_pkg::HMS_RESET;
            r_run    <= 1'b0;
            r_unit   <= 1'b0;
            r_colon  <= 1'b0;
        end else if (i_en) begin
            r_count  <= n_count;
            r_preset <= n_preset;
            r_run    <= n_run;
            r_unit   <= n_unit;
            r_colon  <= n_colon;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// ===== rtl/core/cdt_checker.sv =====
// ----------------------------------------------------------------------------
// Countdown timer checker
// Port-level assertions on result beats, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cdt_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_res_valid,
    input wire logic [cdt_pkg::DIGIT_W-1:0]   i_digit_one,
    input wire logic [cdt_pkg::DIGIT_W-1:0]   i_digit_two,
    input wire logic                          i_hours_view,
    input wire logic                          i_running,
    input wire logic                          i_expired,
    input wire logic                          i_start_beep
);

    // No result beat is offered right after reset.
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result beat offered right after reset");

    // Expiry stops the count, so it never shows together with running or a start beep.
    a_expired_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_expired |-> !i_running && !i_start_beep)
        else $error("expired beat with count still running");

    // A start beep only comes with a running count.
    a_beep_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_start_beep |-> i_running)
        else $error("start beep without running count");

    // Blank leading digit only in the hours view; the second digit stays decimal.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_digit_two <= cdt_pkg::DIGIT_MAX) &&
                        ((i_digit_one <= cdt_pkg::DIGIT_MAX) ||
                         (i_digit_one == cdt_pkg::DIGIT_BLANK && i_hours_view)))
        else $error("display digit out of range");

endmodule

bind countdown_timer_controller cdt_checker u_cdt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res.valid),
    .i_digit_one  (o_res.digit_one),
    .i_digit_two  (o_res.digit_two),
    .i_hours_view (o_res.hours_view),
    .i_running    (o_res.running),
    .i_expired    (o_res.expired),
    .i_start_beep (o_res.start_beep)
);

`default_nettype wire

// ===== test/tb_countdown_timer_controller.sv =====
// ----------------------------------------------------------------------------
// Countdown timer controller testbench
// Drives tick and button beats into the timer and checks every display beat
// against a cycle-free model of the count, the preset and the status flags.
// Directed tests cover editing, floors, expiry and run controls; hour carry
// and saturation are walked explicitly; random sessions of edit, reload,
// start and countdown run under three idling profiles and hours limits.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_countdown_timer_controller;

    // Seconds in a minute, and the base of the display digits.
    localparam int SECS_PER_MIN = 60;
    localparam int RADIX        = 10;

    // The run is stopped here if the display beats stop coming.
    localparam int CYCLE_LIMIT = 500000;

    // Cycles of quiet after the last display beat before a register write
    // or the end of the run.
    localparam int SETTLE_CYCLES = 4;

    // ------------------------------------------------------------------------
    // Clock, reset and the configuration port.
    // ------------------------------------------------------------------------
    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [cdt_pkg::PADDR_W-1:0]   paddr;
    logic [cdt_pkg::PDATA_W-1:0]   pwdata;
    wire  [cdt_pkg::PDATA_W-1:0]   prdata;
    wire                           pready;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    cdt_evt_if evt_ch ();
    cdt_res_if res_ch ();

    countdown_timer_controller dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // Timer model state. It mirrors what the block holds after each accepted
    // event beat, so the stimulus can also steer on it (for example to keep
    // the preset short enough that a countdown reaches zero).
    // ------------------------------------------------------------------------
    cdt_pkg::t_hms               count_hms;
    cdt_pkg::t_hms               preset_hms;
    logic                        run_on;
    logic                        unit_hours;
    logic                        colon_lit;
    logic [cdt_pkg::HOURS_W-1:0] limit_reg;

    // Display beats predicted but not yet seen, oldest first.
    cdt_pkg::t_res expected_displays[$];
    cdt_pkg::t_res want;

    int mismatch_count = 0;
    int beats_sent     = 0;
    int cycle_count    = 0;

    // Percentages of cycles in which the sender holds off and the receiver
    // drops ready.
    int send_gap_pct;
    int recv_gap_pct;

    function automatic int hms_seconds(input cdt_pkg::t_hms t);
        return int'(t.h) * SECS_PER_MIN * SECS_PER_MIN + int'(t.m) * SECS_PER_MIN
               + int'(t.s);
    endfunction

    // One step up by a second or a minute. Seconds carry into minutes and
    // minutes into hours; hours then clamp to the limit, which itself never
    // goes above 99. Minutes keep their wrapped value on a clamp.
    function automatic cdt_pkg::t_hms hms_inc(input cdt_pkg::t_hms t, input logic by_minute);
        int            h;
        int            m;
        int            s;
        int            lim;
        cdt_pkg::t_hms r;
        lim = (limit_reg > cdt_pkg::HOURS_MAX) ? int'(cdt_pkg::HOURS_MAX) : int'(limit_reg);
        h = t.h;
        m = t.m;
        s = int'(t.s) + (by_minute ? SECS_PER_MIN : 1);
        if (s > int'(cdt_pkg::UNIT_MAX)) begin
            s -= SECS_PER_MIN;
            m++;
            if (m > int'(cdt_pkg::UNIT_MAX)) begin
                m -= SECS_PER_MIN;
                h++;
                if (h > lim) begin
                    h = lim;
                end
            end
        end
        r.h = h[cdt_pkg::HOURS_W-1:0];
        r.m = m[cdt_pkg::MIN_W-1:0];
        r.s = s[cdt_pkg::SEC_W-1:0];
        return r;
    endfunction

    // One step down with borrow. A value smaller than one step that has no
    // minutes or hours to borrow from stays as it is.
    function automatic cdt_pkg::t_hms hms_dec(input cdt_pkg::t_hms t, input logic by_minute);
        int            h;
        int            m;
        int            s;
        int            amt;
        cdt_pkg::t_hms r;
        h = t.h;
        m = t.m;
        s = t.s;
        amt = by_minute ? SECS_PER_MIN : 1;
        if (s < amt) begin
            if (m == 0) begin
                if (h == 0) begin
                    return t;
                end
                h--;
                m += SECS_PER_MIN;
            end
            m--;
            s += SECS_PER_MIN;
        end
        s -= amt;
        r.h = h[cdt_pkg::HOURS_W-1:0];
        r.m = m[cdt_pkg::MIN_W-1:0];
        r.s = s[cdt_pkg::SEC_W-1:0];
        return r;
    endfunction

    // Applies one event beat to the model and returns the display beat that
    // the block must produce for it.
    task automatic predict_display(input cdt_pkg::t_op op, input logic sm,
                                   output cdt_pkg::t_res r);
        cdt_pkg::t_hms shown;
        logic          expired_now;
        logic          beep_now;
        int            upper;
        int            lower;
        int            digit_val;
        expired_now = 1'b0;
        beep_now    = 1'b0;
        if (op == cdt_pkg::OP_TICK) begin
            // The colon blinks and a running count goes down in either mode.
            colon_lit = !colon_lit;
            if (run_on) begin
                count_hms = hms_dec(count_hms, 1'b0);
                if (count_hms == cdt_pkg::HMS_ZERO) begin
                    run_on      = 1'b0;
                    count_hms   = preset_hms;
                    expired_now = 1'b1;
                end
            end
        end else if (sm) begin
            case (op)
                cdt_pkg::OP_SNOOZE: begin
                    unit_hours = !unit_hours;
                end
                cdt_pkg::OP_UP: begin
                    preset_hms = hms_inc(preset_hms, unit_hours);
                end
                default: begin
                    preset_hms = hms_dec(preset_hms, unit_hours);
                end
            endcase
        end else if (op == cdt_pkg::OP_SNOOZE) begin
            run_on   = !run_on;
            beep_now = run_on;
        end else if (op == cdt_pkg::OP_UP) begin
            run_on    = 1'b0;
            count_hms = preset_hms;
        end
        // A down press in run mode changes nothing.

        // The hh:mm view shows hours and minutes, the mm:ss view minutes and
        // seconds; a single-digit hours value leaves the first digit blank.
        shown = sm ? preset_hms : count_hms;
        if (unit_hours) begin
            upper = int'(shown.h);
            lower = int'(shown.m);
        end else begin
            upper = int'(shown.m);
            lower = int'(shown.s);
        end
        digit_val     = upper / RADIX;
        r.digit_one   = digit_val[cdt_pkg::DIGIT_W-1:0];
        digit_val     = upper % RADIX;
        r.digit_two   = digit_val[cdt_pkg::DIGIT_W-1:0];
        digit_val     = lower / RADIX;
        r.digit_three = digit_val[cdt_pkg::DIGIT_W-1:0];
        digit_val     = lower % RADIX;
        r.digit_four  = digit_val[cdt_pkg::DIGIT_W-1:0];
        if (unit_hours && upper <= 9) begin
            r.digit_one = cdt_pkg::DIGIT_BLANK;
        end
        r.colon_on   = colon_lit;
        r.hours_view = unit_hours;
        r.running    = run_on;
        r.expired    = expired_now;
        r.start_beep = beep_now;
    endtask

    // ------------------------------------------------------------------------
    // Event sender. Valid stays high from one beat to the next unless the
    // sender decides to hold off, so valid is never lowered and raised in the
    // same time step. The model is advanced at the edge that takes the beat.
    // ------------------------------------------------------------------------
    task automatic send_event(input cdt_pkg::t_op op, input logic sm);
        cdt_pkg::t_res r;
        while ($urandom_range(99) < send_gap_pct) begin
            evt_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        evt_ch.valid    <= 1'b1;
        evt_ch.op       <= op;
        evt_ch.set_mode <= sm;
        do begin
            @(posedge i_clk);
        end while (!evt_ch.ready);
        predict_display(op, sm, r);
        expected_displays.push_back(r);
        beats_sent++;
    endtask

    // Stops sending and waits until every display beat has come back, then
    // waits out the settle time so that nothing is left inside the block.
    task automatic settle_events();
        evt_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_displays.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write of the hours limit register, a setup then an access phase. Only
    // the low seven bits of the word reach the register.
    task automatic write_hours_limit(input logic [cdt_pkg::PDATA_W-1:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {cdt_pkg::REG_HOURS_LIMIT, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        limit_reg  = word[cdt_pkg::HOURS_W-1:0];
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Display checker and receiver. Every beat taken is compared field by
    // field with the oldest prediction; ready is redrawn at each edge.
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name,
                                        input logic [cdt_pkg::DIGIT_W-1:0] exp_val,
                                        input logic [cdt_pkg::DIGIT_W-1:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_displays.size() == 0) begin
                $error("display beat arrived with no event waiting for it");
                mismatch_count++;
            end else begin
                want = expected_displays.pop_front();
                check_field("digit_one", want.digit_one, res_ch.digit_one);
                check_field("digit_two", want.digit_two, res_ch.digit_two);
                check_field("digit_three", want.digit_three, res_ch.digit_three);
                check_field("digit_four", want.digit_four, res_ch.digit_four);
                check_field("colon_on", want.colon_on, res_ch.colon_on);
                check_field("hours_view", want.hours_view, res_ch.hours_view);
                check_field("running", want.running, res_ch.running);
                check_field("expired", want.expired, res_ch.expired);
                check_field("start_beep", want.start_beep, res_ch.start_beep);
            end
        end
        res_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    // Watchdog: a lost or stuck display beat ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // From the reset preset of one minute: the first tick lights the colon,
    // then seconds and minutes steps with carry, borrow and both floors. The
    // preset ends at zero in seconds unit.
    task automatic test_preset_editing();
        send_event(cdt_pkg::OP_TICK, 1'b0);
        send_event(cdt_pkg::OP_UP, 1'b1);
        send_event(cdt_pkg::OP_DOWN, 1'b1);
        send_event(cdt_pkg::OP_DOWN, 1'b1);     // borrow from the minute
        send_event(cdt_pkg::OP_SNOOZE, 1'b1);   // minute unit, hh:mm view with blank
        send_event(cdt_pkg::OP_DOWN, 1'b1);     // under one minute, nothing to borrow
        send_event(cdt_pkg::OP_UP, 1'b1);
        send_event(cdt_pkg::OP_DOWN, 1'b1);
        send_event(cdt_pkg::OP_SNOOZE, 1'b1);
        send_event(cdt_pkg::OP_UP, 1'b1);       // seconds carry into minutes
        send_event(cdt_pkg::OP_SNOOZE, 1'b1);
        send_event(cdt_pkg::OP_DOWN, 1'b1);     // exactly one minute down to zero
        send_event(cdt_pkg::OP_SNOOZE, 1'b1);
        send_event(cdt_pkg::OP_DOWN, 1'b1);     // zero stays zero
    endtask

    // Run controls and expiry, starting from a zero preset.
    task automatic test_countdown_expiry();
        send_event(cdt_pkg::OP_DOWN, 1'b0);     // ignored in run mode
        send_event(cdt_pkg::OP_UP, 1'b0);       // reload the zero preset
        send_event(cdt_pkg::OP_SNOOZE, 1'b0);   // start, with the start beep
        send_event(cdt_pkg::OP_TICK, 1'b0);     // already at zero: stop and expire
        send_event(cdt_pkg::OP_UP, 1'b1);
        send_event(cdt_pkg::OP_UP, 1'b1);
        send_event(cdt_pkg::OP_UP, 1'b0);
        send_event(cdt_pkg::OP_SNOOZE, 1'b0);
        send_event(cdt_pkg::OP_TICK, 1'b1);     // the count runs in set mode too
        send_event(cdt_pkg::OP_TICK, 1'b0);     // reaches zero and reloads
        send_event(cdt_pkg::OP_SNOOZE, 1'b0);
        send_event(cdt_pkg::OP_SNOOZE, 1'b0);   // pause, no beep
        send_event(cdt_pkg::OP_UP, 1'b0);       // stop and reload
    endtask

    // Minute steps across the hour boundary: a limit of zero holds hours at
    // zero, a limit of one lets one carry through and then clamps. The preset
    // is walked back below an hour afterwards.
    task automatic test_hours_carry();
        settle_events();
        write_hours_limit(32'd0);
        if (!unit_hours) begin
            send_event(cdt_pkg::OP_SNOOZE, 1'b1);
        end
        while (preset_hms.m != cdt_pkg::UNIT_MAX) begin
            send_event(cdt_pkg::OP_UP, 1'b1);
        end
        send_event(cdt_pkg::OP_UP, 1'b1);
        settle_events();
        write_hours_limit(32'd1);
        while (!(preset_hms.h == 1 && preset_hms.m == cdt_pkg::UNIT_MAX)) begin
            send_event(cdt_pkg::OP_UP, 1'b1);
        end
        send_event(cdt_pkg::OP_UP, 1'b1);
        send_event(cdt_pkg::OP_UP, 1'b1);
        while (preset_hms.h != 0) begin
            send_event(cdt_pkg::OP_DOWN, 1'b1);
        end
    endtask

    // Random sessions: edit the preset, reload, start and count down past
    // zero, with presses mixed into the countdown. Some bursts are plain
    // noise. The preset is steered short so that most countdowns expire.
    task automatic test_random_sessions(input int beats, input int send_gap,
                                        input int recv_gap,
                                        input logic [cdt_pkg::PDATA_W-1:0] limit_word);
        int first;
        int edits;
        int ticks;
        int pick;
        int secs;
        settle_events();
        write_hours_limit(limit_word);
        send_gap_pct = send_gap;
        recv_gap_pct = recv_gap;
        first = beats_sent;
        while (beats_sent - first < beats) begin
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(1, 4)) begin
                    send_event(cdt_pkg::t_op'($urandom_range(3)), 1'($urandom_range(1)));
                end
            end else begin
                edits = $urandom_range(1, 10);
                repeat (edits) begin
                    pick = $urandom_range(99);
                    if (pick < 15) begin
                        send_event(cdt_pkg::OP_SNOOZE, 1'b1);
                    end else if (pick < 60 && hms_seconds(preset_hms) <= 90) begin
                        send_event(cdt_pkg::OP_UP, 1'b1);
                    end else begin
                        send_event(cdt_pkg::OP_DOWN, 1'b1);
                    end
                end
                if ($urandom_range(99) < 80) begin
                    send_event(cdt_pkg::OP_UP, 1'b0);
                end
                if ($urandom_range(99) < 90) begin
                    send_event(cdt_pkg::OP_SNOOZE, 1'b0);
                end
                secs = hms_seconds(count_hms);
                ticks = (secs <= 80) ? secs + $urandom_range(0, 3) : $urandom_range(5, 40);
                repeat (ticks) begin
                    pick = $urandom_range(99);
                    if (pick < 80) begin
                        send_event(cdt_pkg::OP_TICK, 1'b0);
                    end else if (pick < 88) begin
                        send_event(cdt_pkg::OP_TICK, 1'b1);
                    end else if (pick < 92) begin
                        send_event(cdt_pkg::OP_SNOOZE, 1'b0);
                    end else if (pick < 95) begin
                        send_event(cdt_pkg::OP_DOWN, 1'b0);
                    end else if (pick < 97) begin
                        send_event(cdt_pkg::OP_UP, 1'b0);
                    end else begin
                        send_event(cdt_pkg::t_op'($urandom_range(3)), 1'($urandom_range(1)));
                    end
                end
            end
        end
    endtask

    // With a limit word of 127 (and junk in the upper bits) the limit acts
    // as 99, so a minute step past the top of the hour carries into hours
    // instead of being held back. The new count is then run and shown.
    task automatic test_hours_climb();
        settle_events();
        write_hours_limit(($urandom() & ~32'h7F) | 32'd127);
        if (!unit_hours) begin
            send_event(cdt_pkg::OP_SNOOZE, 1'b1);
        end
        while (preset_hms.h == 0) begin
            send_event(cdt_pkg::OP_UP, 1'b1);
        end
        send_event(cdt_pkg::OP_UP, 1'b1);
        send_event(cdt_pkg::OP_UP, 1'b1);
        send_event(cdt_pkg::OP_UP, 1'b0);
        send_event(cdt_pkg::OP_SNOOZE, 1'b0);
        repeat (3) send_event(cdt_pkg::OP_TICK, 1'b0);
        send_event(cdt_pkg::OP_SNOOZE, 1'b1);
        send_event(cdt_pkg::OP_TICK, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         <= 1'b0;
        evt_ch.valid    <= 1'b0;
        evt_ch.op       <= cdt_pkg::OP_TICK;
        evt_ch.set_mode <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        send_gap_pct     = 11;
        recv_gap_pct     = 59;
        count_hms        = cdt_pkg::HMS_RESET;
        preset_hms       = cdt_pkg::HMS_RESET;
        run_on           = 1'b0;
        unit_hours       = 1'b0;
        colon_lit        = 1'b0;
        limit_reg        = cdt_pkg::LIMIT_RESET;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats start at the reset limit with the first idling mix.
        test_preset_editing();
        test_countdown_expiry();
        test_hours_carry();

        // Three random phases: sender rarely idle and receiver often stalled,
        // then the reverse, then full rate; each under its own limit.
        test_random_sessions(110, 11, 59, 32'd99);
        test_random_sessions(110, 59, 11, 32'd1);
        test_random_sessions(110, 0, 0, $urandom());

        test_hours_climb();

        settle_events();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/cdt_pkg.sv
rtl/core/cdt_evt_if.sv
rtl/core/cdt_res_if.sv
rtl/core/cdt_regs.sv
rtl/core/cdt_core.sv
rtl/core/countdown_timer_controller.sv
rtl/core/cdt_checker.sv
test/tb_countdown_timer_controller.sv
